// ===== rtl/core/ts_continuity_checker_top_assert.svh =====
// Assertion macros for the transport stream continuity checker.
`ifndef TS_CONTINUITY_CHECKER_TOP_ASSERT_SVH
`define TS_CONTINUITY_CHECKER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TSC_ASSERT_IMPLY(lbl, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("ts continuity checker: implication check failed");
`define TSC_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("ts continuity checker: forbidden condition seen");
`else
`define TSC_ASSERT_IMPLY(lbl, cond, prop)
`define TSC_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/tsc_pkg.sv =====
// Shared types and constants of the transport stream continuity checker.
package tsc_pkg;

	localparam int PID_W = 13;
	localparam int CC_W = 4;
	localparam int PID_DEPTH = 2 ** PID_W;
	localparam int ENTRY_W = CC_W + 1;

	localparam logic [7:0] SYNC_BYTE = 8'h47;
	localparam logic [1:0] AFC_ADAPT_ONLY = 2'd2;
	localparam logic [PID_W-1:0] NULL_PACKET_ID_DEF = 13'd8191;

	typedef struct packed {
		logic [PID_W-1:0] packet_id;
		logic [CC_W-1:0]  received_counter;
		logic [CC_W-1:0]  expected_counter;
		logic             sync_error;
		logic             skipped;
		logic             first_seen;
		logic             continuity_error;
	} tsc_result_t;

	typedef struct packed {
		logic item_valid;
		logic clearing;
	} tsc_status_t;

endpackage

// ===== rtl/core/tsc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/tsc_update.sv =====
// Table lookup stage: decode, read-modify-write of the per-PID entry and clearing sweep.
module tsc_update #(
	parameter logic [tsc_pkg::PID_W-1:0] NULL_PACKET_ID = tsc_pkg::NULL_PACKET_ID_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hdr_accept,
	input  logic [31:0]          header_word,
	input  logic                 advance,
	output tsc_pkg::tsc_status_t status,
	output tsc_pkg::tsc_result_t result
);

	import tsc_pkg::*;

	logic               clr_q;
	logic [PID_W-1:0]   clr_addr_q;
	logic               valid_s1;
	logic [PID_W-1:0]   pid_s1;
	logic [CC_W-1:0]    cc_s1;
	logic               sync_err_s1;
	logic               skip_s1;
	logic               lw_valid_q;
	logic [PID_W-1:0]   lw_addr_q;
	logic [ENTRY_W-1:0] lw_data_q;

	logic               hold;
	logic [PID_W-1:0]   in_pid;
	logic [PID_W-1:0]   raddr;
	logic [ENTRY_W-1:0] rdata;
	logic [ENTRY_W-1:0] entry;
	logic               we;
	logic [PID_W-1:0]   waddr;
	logic [ENTRY_W-1:0] wdata;
	logic               seen;
	logic [CC_W-1:0]    next_cc;

	assign hold   = valid_s1 && !advance;
	assign in_pid = header_word[20:8];
	assign raddr  = hold ? pid_s1 : in_pid;

	assign we    = clr_q || (valid_s1 && advance && !skip_s1);
	assign waddr = clr_q ? clr_addr_q : pid_s1;
	assign wdata = clr_q ? '0 : {1'b1, cc_s1};

	tsc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(PID_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// The write made at the edge where this entry was read has not reached the read data.
	assign entry   = (lw_valid_q && lw_addr_q == pid_s1) ? lw_data_q : rdata;
	assign seen    = entry[CC_W];
	assign next_cc = entry[CC_W-1:0] + CC_W'(1);

	always_comb begin
		result.packet_id        = pid_s1;
		result.received_counter = cc_s1;
		result.sync_error       = sync_err_s1;
		result.skipped          = skip_s1;
		result.expected_counter = '0;
		result.first_seen       = 1'b0;
		result.continuity_error = 1'b0;
		if (!skip_s1) begin
			if (seen) begin
				result.expected_counter = next_cc;
				result.continuity_error = (next_cc != cc_s1);
			end else begin
				result.first_seen = 1'b1;
			end
		end
	end

	assign status.item_valid = valid_s1;
	assign status.clearing   = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			valid_s1   <= 1'b0;
			lw_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + PID_W'(1);
				if (clr_addr_q == {PID_W{1'b1}}) begin
					clr_q <= 1'b0;
				end
			end
			if (!hold) begin
				valid_s1 <= hdr_accept;
			end
			if (we) begin
				lw_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			pid_s1      <= in_pid;
			cc_s1       <= header_word[3:0];
			sync_err_s1 <= (header_word[31:24] != SYNC_BYTE);
			skip_s1     <= (header_word[5:4] == AFC_ADAPT_ONLY) || (in_pid == NULL_PACKET_ID);
		end
		if (we) begin
			lw_addr_q <= waddr;
			lw_data_q <= wdata;
		end
	end

endmodule

// ===== rtl/core/ts_continuity_checker_top.sv =====
// Top level of the transport stream continuity checker.
//
//  channel  direction  handshake            payload
//  header   in         hdr_valid/hdr_stall  header_word
//  result   out        res_valid/res_stall  packet_id .. continuity_error
//
// One header transaction per cycle is sustained while res_stall is low and no clearing
// sweep runs; an accepted header passes the table read and then the output register.
// The per-PID table is one RAM of 8192 entries, read once and written at most once per cycle.
// After reset a clearing sweep writes zero to each of the 8192 entries, during which hdr_stall is high.
// A stalled result holds one transaction in the output register and one in the lookup stage.
`include "ts_continuity_checker_top_assert.svh"
module ts_continuity_checker_top #(
	parameter logic [tsc_pkg::PID_W-1:0] NULL_PACKET_ID = tsc_pkg::NULL_PACKET_ID_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hdr_valid,
	output logic                      hdr_stall,
	input  logic [31:0]               header_word,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [tsc_pkg::PID_W-1:0] packet_id,
	output logic [tsc_pkg::CC_W-1:0]  received_counter,
	output logic [tsc_pkg::CC_W-1:0]  expected_counter,
	output logic                      sync_error,
	output logic                      skipped,
	output logic                      first_seen,
	output logic                      continuity_error
);

	import tsc_pkg::*;

	tsc_status_t status;
	tsc_result_t result;
	tsc_result_t res_q;
	logic        res_valid_q;
	logic        advance;
	logic        hdr_accept;

	assign advance    = !res_valid_q || !res_stall;
	assign hdr_stall  = status.clearing || (status.item_valid && !advance);
	assign hdr_accept = hdr_valid && !hdr_stall;

	tsc_update #(
		.NULL_PACKET_ID(NULL_PACKET_ID)
	) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr_accept (hdr_accept),
		.header_word(header_word),
		.advance    (advance),
		.status     (status),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= status.item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && status.item_valid) begin
			res_q <= result;
		end
	end

	assign res_valid        = res_valid_q;
	assign packet_id        = res_q.packet_id;
	assign received_counter = res_q.received_counter;
	assign expected_counter = res_q.expected_counter;
	assign sync_error       = res_q.sync_error;
	assign skipped          = res_q.skipped;
	assign first_seen       = res_q.first_seen;
	assign continuity_error = res_q.continuity_error;

	`TSC_ASSERT_NEVER(a_no_accept_in_clear, hdr_accept && status.clearing)
	`TSC_ASSERT_IMPLY(a_flags_exclusive, res_valid, $onehot0({skipped, first_seen, continuity_error}))
	`TSC_ASSERT_IMPLY(a_error_means_mismatch, res_valid && continuity_error, expected_counter != received_counter)
	`TSC_ASSERT_IMPLY(a_clear_holds_pipe, status.clearing, !status.item_valid && !res_valid_q)

endmodule

// ===== tb/tsc_result_checker.sv =====
// Watches both channels of the continuity checker, predicts each result and compares it.
`timescale 1ns / 1ps
module tsc_result_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hdr_valid,
	input  logic                      hdr_stall,
	input  logic [31:0]               header_word,
	input  logic                      res_valid,
	input  logic                      res_stall,
	input  logic [tsc_pkg::PID_W-1:0] packet_id,
	input  logic [tsc_pkg::CC_W-1:0]  received_counter,
	input  logic [tsc_pkg::CC_W-1:0]  expected_counter,
	input  logic                      sync_error,
	input  logic                      skipped,
	input  logic                      first_seen,
	input  logic                      continuity_error,
	output int                        fail_count,
	output int                        pending,
	output int                        results_checked,
	output int                        first_count,
	output int                        break_count,
	output int                        skip_count
);

	import tsc_pkg::*;

	bit [PID_DEPTH-1:0] pid_recorded;
	logic [CC_W-1:0]    stored_counter [PID_DEPTH];
	tsc_result_t        awaited_results [$];

	function automatic tsc_result_t predict_header(logic [31:0] word);
		tsc_result_t      r;
		logic [PID_W-1:0] pid;
		logic [1:0]       afc;
		logic [CC_W-1:0]  cc;
		pid = word[20:8];
		afc = word[5:4];
		cc = word[3:0];
		r = '0;
		r.packet_id = pid;
		r.received_counter = cc;
		r.sync_error = (word[31:24] != SYNC_BYTE);
		if (afc == AFC_ADAPT_ONLY || pid == NULL_PACKET_ID_DEF) begin
			r.skipped = 1'b1;
		end else if (pid_recorded[pid]) begin
			r.expected_counter = stored_counter[pid] + CC_W'(1);
			r.continuity_error = (r.expected_counter != cc);
			stored_counter[pid] = cc;
		end else begin
			r.first_seen = 1'b1;
			pid_recorded[pid] = 1'b1;
			stored_counter[pid] = cc;
		end
		return r;
	endfunction

	task automatic report_failure(string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string field, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_failure($sformatf("result %0d: %s is %0h, expected %0h",
				results_checked, field, got, want));
	endtask

	task automatic compare_result(tsc_result_t want);
		check_field("packet_id", 16'(packet_id), 16'(want.packet_id));
		check_field("received_counter", 16'(received_counter),
			16'(want.received_counter));
		check_field("expected_counter", 16'(expected_counter),
			16'(want.expected_counter));
		check_field("sync_error", 16'(sync_error), 16'(want.sync_error));
		check_field("skipped", 16'(skipped), 16'(want.skipped));
		check_field("first_seen", 16'(first_seen), 16'(want.first_seen));
		check_field("continuity_error", 16'(continuity_error),
			16'(want.continuity_error));
	endtask

	always @(posedge clk) begin
		tsc_result_t r;
		if (!arst_n) begin
			pid_recorded = '0;
			awaited_results.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			first_count = 0;
			break_count = 0;
			skip_count = 0;
		end else begin
			if (hdr_valid && !hdr_stall) begin
				r = predict_header(header_word);
				first_count += int'(r.first_seen);
				break_count += int'(r.continuity_error);
				skip_count += int'(r.skipped);
				awaited_results.push_back(r);
			end
			if (res_valid && !res_stall) begin
				if (awaited_results.size() == 0)
					report_failure($sformatf("result for PID %0h arrived with nothing pending",
						packet_id));
				else
					compare_result(awaited_results.pop_front());
				results_checked++;
			end
			pending = awaited_results.size();
		end
	end

endmodule

// ===== tb/tb_ts_continuity_checker_top.sv =====
// Stimulus, reset and verdict for the transport stream continuity checker.
`timescale 1ns / 1ps
module tb_ts_continuity_checker_top;
	import tsc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_HEADERS = 1400;
	localparam int POOL_SIZE = 12;
	localparam int LONG_HOLD = 400;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             hdr_valid = 1'b0;
	logic             hdr_stall;
	logic [31:0]      header_word = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	logic [PID_W-1:0] packet_id;
	logic [CC_W-1:0]  received_counter;
	logic [CC_W-1:0]  expected_counter;
	logic             sync_error;
	logic             skipped;
	logic             first_seen;
	logic             continuity_error;

	int fail_count;
	int pending;
	int results_checked;
	int first_count;
	int break_count;
	int skip_count;
	int headers_sent = 0;
	bit sender_idles = 1'b1;
	bit long_hold_due = 1'b0;

	ts_continuity_checker_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.hdr_valid        (hdr_valid),
		.hdr_stall        (hdr_stall),
		.header_word      (header_word),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.packet_id        (packet_id),
		.received_counter (received_counter),
		.expected_counter (expected_counter),
		.sync_error       (sync_error),
		.skipped          (skipped),
		.first_seen       (first_seen),
		.continuity_error (continuity_error)
	);

	tsc_result_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.hdr_valid        (hdr_valid),
		.hdr_stall        (hdr_stall),
		.header_word      (header_word),
		.res_valid        (res_valid),
		.res_stall        (res_stall),
		.packet_id        (packet_id),
		.received_counter (received_counter),
		.expected_counter (expected_counter),
		.sync_error       (sync_error),
		.skipped          (skipped),
		.first_seen       (first_seen),
		.continuity_error (continuity_error),
		.fail_count       (fail_count),
		.pending          (pending),
		.results_checked  (results_checked),
		.first_count      (first_count),
		.break_count      (break_count),
		.skip_count       (skip_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [31:0] build_header(logic [7:0] sync, logic [PID_W-1:0] pid,
		logic [1:0] afc, logic [CC_W-1:0] cc, logic [4:0] spare);
		return {sync, spare[4:2], pid, spare[1:0], afc, cc};
	endfunction

	task automatic send_header(logic [31:0] word);
		int gap;
		gap = sender_idles ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			hdr_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr_valid <= 1'b1;
		header_word <= word;
		do @(posedge clk); while (hdr_stall);
		headers_sent++;
	endtask

	initial begin : header_source
		logic [31:0]      directed [$];
		logic [PID_W-1:0] pool_pid [POOL_SIZE];
		logic [CC_W-1:0]  pool_next [POOL_SIZE];
		logic [1:0]       afc;
		logic [7:0]       sync;
		logic [CC_W-1:0]  cc;
		int               kind;
		int               slot;
		wait (arst_n);
		@(posedge clk);

		directed.push_back(build_header(SYNC_BYTE, 13'd0, 2'd1, 4'd5, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, 13'd0, 2'd1, 4'd6, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, 13'd0, 2'd3, 4'd8, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, 13'd0, 2'd0, 4'd9, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, 13'd0, AFC_ADAPT_ONLY, 4'd3, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, 13'd0, 2'd1, 4'd10, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, NULL_PACKET_ID_DEF, 2'd1, 4'd4, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, NULL_PACKET_ID_DEF, 2'd3, 4'd4, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, 13'd8190, 2'd1, 4'd15, 5'h1f));
		directed.push_back(build_header(SYNC_BYTE, 13'd8190, 2'd1, 4'd0, 5'h1f));
		directed.push_back(build_header(SYNC_BYTE, 13'd8190, 2'd3, 4'd0, 5'd0));
		directed.push_back(build_header(8'h00, 13'd100, 2'd1, 4'd0, 5'd0));
		directed.push_back(build_header(8'hff, 13'd100, 2'd1, 4'd1, 5'd0));
		directed.push_back(build_header(8'h46, 13'd100, 2'd1, 4'd7, 5'd0));
		directed.push_back(32'hffff_ffff);
		directed.push_back(32'h0000_0000);
		directed.push_back(build_header(SYNC_BYTE, 13'd42, 2'd3, 4'd12, 5'h0a));
		directed.push_back(build_header(SYNC_BYTE, 13'd42, 2'd3, 4'd13, 5'h15));
		directed.push_back(build_header(SYNC_BYTE, 13'd42, 2'd1, 4'd14, 5'h0a));
		directed.push_back(build_header(SYNC_BYTE, 13'd42, 2'd1, 4'd15, 5'h15));
		directed.push_back(build_header(SYNC_BYTE, 13'd42, 2'd0, 4'd0, 5'd0));
		directed.push_back(build_header(SYNC_BYTE, 13'd42, 2'd1, 4'd1, 5'd0));
		foreach (directed[i])
			send_header(directed[i]);

		pool_pid[0] = 13'd0;
		pool_pid[1] = 13'd8190;
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (i > 1)
				pool_pid[i] = PID_W'($urandom_range(1, 8189));
			pool_next[i] = CC_W'($urandom);
		end

		for (int n = 0; n < RANDOM_HEADERS; n++) begin
			if (n % 100 == 0)
				sender_idles = ($urandom_range(0, 2) != 0);
			if (n == 300)
				long_hold_due = 1'b1;
			kind = $urandom_range(0, 99);
			slot = $urandom_range(0, POOL_SIZE - 1);
			if (kind < 80) begin
				if ($urandom_range(0, 9) == 0)
					afc = AFC_ADAPT_ONLY;
				else if ($urandom_range(0, 7) == 0)
					afc = 2'd0;
				else
					afc = $urandom_range(0, 1) ? 2'd1 : 2'd3;
				sync = ($urandom_range(0, 49) == 0) ? 8'($urandom) : SYNC_BYTE;
				send_header(build_header(sync, pool_pid[slot], afc, pool_next[slot],
					5'($urandom)));
				if (afc != AFC_ADAPT_ONLY)
					pool_next[slot] = pool_next[slot] + CC_W'(1);
			end else if (kind < 90) begin
				cc = CC_W'($urandom);
				send_header(build_header(SYNC_BYTE, pool_pid[slot], 2'd1, cc, 5'($urandom)));
				pool_next[slot] = cc + CC_W'(1);
			end else if (kind < 94) begin
				send_header(build_header(SYNC_BYTE, NULL_PACKET_ID_DEF, 2'($urandom),
					4'($urandom), 5'($urandom)));
			end else begin
				send_header($urandom);
			end
		end
		hdr_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		$display("Sent %0d headers and checked %0d results after the table sweep.",
			headers_sent, results_checked);
		$display("Predicted %0d first sightings, %0d continuity breaks and %0d skipped packets.",
			first_count, break_count, skip_count);
		if (fail_count == 0)
			$display("ts_continuity_checker_top test passed");
		else
			$display("ts_continuity_checker_top test failed");
		$finish;
	end

	initial begin : result_sink
		int  hold;
		bit  sink_idles;
		sink_idles = 1'b1;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				sink_idles = !sink_idles;
			hold = sink_idles ? $urandom_range(0, 7) : 0;
			if (long_hold_due) begin
				hold = LONG_HOLD;
				long_hold_due = 1'b0;
			end
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ts_continuity_checker_top test failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tsc_pkg.sv
rtl/core/tsc_ram.sv
rtl/core/tsc_update.sv
rtl/core/ts_continuity_checker_top.sv
tb/tsc_result_checker.sv
tb/tb_ts_continuity_checker_top.sv
